>>> hw/rtl/olirs_pkg.sv
// Shared types, codes and defaults for the ordered list block.
// Used by the cell, the find-first tree, the top level and the checker.
`default_nettype none

package olirs_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_ELEM_WIDTH = 32;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_VISIT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic ins;
      logic rem;
      logic srch;
      logic vis;
   } cell_op_type;

endpackage

`default_nettype wire

>>> hw/rtl/olirs_cell.sv
// One storage cell of the list row: holds one entry, shifts with its neighbors,
// and produces its leaf bit for the find-first tree. Depends on olirs_pkg.
`default_nettype none

module olirs_cell #(
   parameter int ELEM_WIDTH = olirs_pkg::DEF_ELEM_WIDTH,
   parameter int POS_W      = 7,
   parameter int INDEX      = 0
) (
   input  wire                          clock,
   input  olirs_pkg::cell_op_type       op,
   input  wire [POS_W-1:0]              pos,
   input  wire [POS_W-1:0]              count,
   input  wire [ELEM_WIDTH-1:0]         key,
   input  wire [ELEM_WIDTH-1:0]         prev_q,
   input  wire [ELEM_WIDTH-1:0]         next_q,
   output logic [ELEM_WIDTH-1:0]        q,
   output logic                         hit
);
   import olirs_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [ELEM_WIDTH-1:0] entry_ff;
   logic [ELEM_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (IDX > pos) begin
            entry_in = prev_q;
         end else if (IDX == pos) begin
            entry_in = key;
         end
      end else if (op.rem && (IDX >= pos)) begin
         entry_in = next_q;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_comb begin
      hit = 1'b0;
      if (op.srch) begin
         hit = (IDX < count) && (entry_ff == key);
      end else if (op.vis) begin
         hit = (IDX == pos);
      end
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

>>> hw/rtl/olirs_ffs.sv
// Iterative find-first tree: loads one leaf bit and entry per cell, then halves
// the set once per cycle until node zero holds the lowest hit. Depends on olirs_pkg.
`default_nettype none

module olirs_ffs #(
   parameter int LEAVES     = olirs_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = olirs_pkg::DEF_ELEM_WIDTH,
   parameter int IDX_W      = $clog2(LEAVES)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire                   ack,
   input  wire [LEAVES-1:0]      hits,
   input  wire [ELEM_WIDTH-1:0]  leaf_data [LEAVES],
   output logic                  done,
   output logic                  found,
   output logic [IDX_W-1:0]      index,
   output logic [ELEM_WIDTH-1:0] data
);
   import olirs_pkg::*;

   localparam int STEPS = $clog2(LEAVES);
   localparam int NODES = 1 << STEPS;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [NODES-1:0]      v_ff;
   logic [IDX_W-1:0]      i_ff [NODES];
   logic [ELEM_WIDTH-1:0] d_ff [NODES];
   logic [NODES-1:0]      leaf_v;
   logic [ELEM_WIDTH-1:0] leaf_d [NODES];
   logic                  run_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  last_step;

   for (genvar k = 0; k < NODES; k++) begin : g_leaf
      if (k < LEAVES) begin : g_real
         assign leaf_v[k] = hits[k];
         assign leaf_d[k] = leaf_data[k];
      end else begin : g_pad
         assign leaf_v[k] = 1'b0;
         assign leaf_d[k] = '0;
      end
   end

   assign last_step = (step_ff == STEP_W'(STEPS));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else if (load) begin
         run_ff  <= 1'b1;
         step_ff <= '0;
      end else if (run_ff && ack) begin
         run_ff  <= 1'b0;
      end else if (run_ff && !last_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NODES; k++) begin
            v_ff[k] <= leaf_v[k];
            i_ff[k] <= IDX_W'(k);
            d_ff[k] <= leaf_d[k];
         end
      end else if (run_ff && !last_step) begin
         // pair up neighbors, keep the lower one that hits
         for (int k = 0; k < NODES / 2; k++) begin
            v_ff[k] <= v_ff[2*k] | v_ff[2*k+1];
            i_ff[k] <= v_ff[2*k] ? i_ff[2*k] : i_ff[2*k+1];
            d_ff[k] <= v_ff[2*k] ? d_ff[2*k] : d_ff[2*k+1];
         end
      end
   end

   assign done  = run_ff && last_step;
   assign found = v_ff[0];
   assign index = i_ff[0];
   assign data  = d_ff[0];

endmodule

`default_nettype wire

>>> hw/rtl/ordered_list_insert_remove_search.sv
// Top level of the ordered list: a row of entry cells, a find-first tree and
// the command sequencer. Depends on olirs_pkg, olirs_cell and olirs_ffs.
//
//   channel  dir  tuser         tdata (lowest bit up)
//   req_     in   cmd [2:0]     position [6:0], value [38:7], zero pad to 40
//   rsp_     out  -             status [1:0], found_index [7:2],
//                               read_value [39:8], length [46:40], pad to 48
//
// Insert, remove, clear, unknown commands and a visit out of range: result
// registered on accept; on insert or remove the cells from the position up
// shift in that same cycle. Search and an in-range visit: result waits on the
// find-first tree, which halves its candidates once per cycle.
// A new item is taken when no search or visit is in flight and the result
// register is empty or being emptied. Reset (synchronous) empties the list;
// entry contents are not cleared. A stalled result holds until taken.
`default_nettype none

module ordered_list_insert_remove_search #(
   parameter int CAPACITY   = olirs_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = olirs_pkg::DEF_ELEM_WIDTH,
   parameter int POS_W      = $clog2(CAPACITY + 1),
   parameter int IDX_W      = $clog2(CAPACITY),
   parameter int REQ_W      = ((POS_W + olirs_pkg::VALUE_W + 7) / 8) * 8,
   parameter int RSP_W      = ((olirs_pkg::STATUS_W + IDX_W + olirs_pkg::VALUE_W
                                + POS_W + 7) / 8) * 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [REQ_W-1:0]                req_tdata,  // position, value, pad
   input  wire [olirs_pkg::CMD_W-1:0]     req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [RSP_W-1:0]               rsp_tdata   // status, found_index,
                                                      // read_value, length, pad
);
   import olirs_pkg::*;

   localparam int RSP_USED = STATUS_W + IDX_W + VALUE_W + POS_W;
   localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      count_ff, count_in;
   logic                  busy_vis_ff, busy_vis_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IDX_W-1:0]      found_ff, found_in;
   logic [VALUE_W-1:0]    read_ff, read_in;
   logic [POS_W-1:0]      length_ff, length_in;

   logic [CMD_W-1:0]      req_cmd;
   logic [POS_W-1:0]      req_position;
   logic [VALUE_W-1:0]    req_value;
   logic [ELEM_WIDTH-1:0] key;
   logic                  req_accept;
   logic                  slot_free;

   cell_op_type           op;
   logic                  tree_load;
   logic                  tree_ack;
   logic                  tree_done;
   logic                  tree_found;
   logic [IDX_W-1:0]      tree_index;
   logic [ELEM_WIDTH-1:0] tree_data;
   logic [VALUE_W-1:0]    tree_read;

   logic [ELEM_WIDTH-1:0] entry_q [CAPACITY];
   logic [CAPACITY-1:0]   hits;

   assign req_cmd      = req_tuser;
   assign req_position = req_tdata[POS_W-1:0];
   assign req_value    = req_tdata[POS_W +: VALUE_W];

   if (ELEM_WIDTH <= VALUE_W) begin : g_key_trunc
      assign key = req_value[ELEM_WIDTH-1:0];
   end else begin : g_key_ext
      assign key = {{(ELEM_WIDTH - VALUE_W){req_value[VALUE_W-1]}}, req_value};
   end

   if (ELEM_WIDTH >= VALUE_W) begin : g_rd_trunc
      assign tree_read = tree_data[VALUE_W-1:0];
   end else begin : g_rd_ext
      assign tree_read = {{(VALUE_W - ELEM_WIDTH){tree_data[ELEM_WIDTH-1]}}, tree_data};
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_accept = req_tvalid && req_tready;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] prev_q;
      logic [ELEM_WIDTH-1:0] next_q;
      if (i == 0) begin : g_first
         assign prev_q = '0;
      end else begin : g_mid_lo
         assign prev_q = entry_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_q = '0;
      end else begin : g_mid_hi
         assign next_q = entry_q[i+1];
      end
      olirs_cell #(
         .ELEM_WIDTH(ELEM_WIDTH),
         .POS_W     (POS_W),
         .INDEX     (i)
      ) u_cell (
         .clock (clock),
         .op    (op),
         .pos   (req_position),
         .count (count_ff),
         .key   (key),
         .prev_q(prev_q),
         .next_q(next_q),
         .q     (entry_q[i]),
         .hit   (hits[i])
      );
   end

   olirs_ffs #(
      .LEAVES    (CAPACITY),
      .ELEM_WIDTH(ELEM_WIDTH),
      .IDX_W     (IDX_W)
   ) u_ffs (
      .clock    (clock),
      .reset    (reset),
      .load     (tree_load),
      .ack      (tree_ack),
      .hits     (hits),
      .leaf_data(entry_q),
      .done     (tree_done),
      .found    (tree_found),
      .index    (tree_index),
      .data     (tree_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      busy_vis_in  = busy_vis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      found_in     = found_ff;
      read_in      = read_ff;
      length_in    = length_ff;
      op           = '0;
      tree_load    = 1'b0;
      tree_ack     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in = ST_OK;
               found_in  = '0;
               read_in   = '0;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff == CAP) begin
                        status_in = ST_FULL;
                     end else if (req_position > count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        op.ins   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (req_position >= count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        op.rem   = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     op.srch     = 1'b1;
                     tree_load   = 1'b1;
                     busy_vis_in = 1'b0;
                  end
                  CMD_VISIT: begin
                     if (req_position >= count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        op.vis      = 1'b1;
                        tree_load   = 1'b1;
                        busy_vis_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               length_in = count_in;
               // search and an in-range visit report from the tree later
               if (tree_load) begin
                  state_in = ST_BUSY;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_BUSY: begin
            if (tree_done && slot_free) begin
               tree_ack     = 1'b1;
               rsp_valid_in = 1'b1;
               length_in    = count_ff;
               if (busy_vis_ff) begin
                  status_in = ST_OK;
                  found_in  = '0;
                  read_in   = tree_read;
               end else begin
                  status_in = tree_found ? ST_OK : ST_NOTFOUND;
                  found_in  = tree_found ? tree_index : '0;
                  read_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      busy_vis_ff <= busy_vis_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      read_ff     <= read_in;
      length_ff   <= length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_USED){1'b0}}, length_ff, read_ff, found_ff, status_ff};

endmodule

`default_nettype wire

>>> hw/rtl/olirs_check.sv
// Port-level checker for the ordered list, attached to the top level by bind.
// Depends on olirs_pkg.
`default_nettype none

module olirs_check #(
   parameter int CAPACITY = olirs_pkg::DEF_CAPACITY,
   parameter int POS_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int RSP_W    = ((olirs_pkg::STATUS_W + IDX_W + olirs_pkg::VALUE_W
                              + POS_W + 7) / 8) * 8
) (
   input wire             clock,
   input wire             reset,
   input wire             rsp_tvalid,
   input wire             rsp_tready,
   input wire [RSP_W-1:0] rsp_tdata
);
   import olirs_pkg::*;

   localparam int FOUND_LO  = STATUS_W;
   localparam int READ_LO   = STATUS_W + IDX_W;
   localparam int LENGTH_LO = STATUS_W + IDX_W + VALUE_W;
   localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    found_index;
   logic [VALUE_W-1:0]  read_value;
   logic [POS_W-1:0]    length;

   assign status      = rsp_tdata[STATUS_W-1:0];
   assign found_index = rsp_tdata[FOUND_LO +: IDX_W];
   assign read_value  = rsp_tdata[READ_LO +: VALUE_W];
   assign length      = rsp_tdata[LENGTH_LO +: POS_W];

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (length <= CAP))
      else $error("length beyond capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status == ST_FULL)) |-> (length == CAP))
      else $error("full status with list not full");

   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((found_index != '0) || (read_value != '0))) |-> (status == ST_OK))
      else $error("result payload set on failed item");

   a_found_xor_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((found_index == '0) || (read_value == '0)))
      else $error("search index and read value both set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind ordered_list_insert_remove_search olirs_check #(
   .CAPACITY(CAPACITY),
   .POS_W   (POS_W),
   .IDX_W   (IDX_W),
   .RSP_W   (RSP_W)
) u_olirs_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

>>> sim/tb_ordered_list_insert_remove_search.sv
// Testbench for the ordered list block: directed corner items, then random
// traffic checked against a shadow list kept in a small scoreboard class.
// Depends on olirs_pkg and ordered_list_insert_remove_search.
`timescale 1ns / 1ps

module tb_ordered_list_insert_remove_search;
   import olirs_pkg::*;

   localparam int REQ_W = 40;
   localparam int RSP_W = 48;
   localparam int N_RANDOM = 900;
   localparam int QUIET_FROM = 800;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_PRINTED = 40;
   localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_PROBE} traffic_mode_e;

   // packed most significant first, so status sits on top
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  found_index;
      logic [31:0] read_value;
      logic [6:0]  length;
   } list_rsp_t;

   class list_shadow;
      logic [31:0] cells [DEF_CAPACITY];
      int unsigned length = 0;
      list_rsp_t   pending_rsp [$];
      int unsigned rsp_seen = 0;
      int unsigned mismatches = 0;
      int unsigned n_full = 0;
      int unsigned n_range = 0;
      int unsigned n_hit = 0;
      int unsigned n_miss = 0;
      int unsigned peak_length = 0;
      int unsigned op_count [8];

      function new();
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      // update the shadow list for an accepted item and queue its response
      function void apply_command(logic [CMD_W-1:0] cmd, logic [6:0] pos,
                                  logic [31:0] value);
         list_rsp_t r;
         int j;
         r = '0;
         case (cmd)
            CMD_INSERT: begin
               if (length >= DEF_CAPACITY) begin
                  r.status = ST_FULL;
               end else if (pos > length) begin
                  r.status = ST_RANGE;
               end else begin
                  for (j = length; j > pos; j--) cells[j] = cells[j-1];
                  cells[pos] = value;
                  length++;
               end
            end
            CMD_REMOVE: begin
               if (pos >= length) begin
                  r.status = ST_RANGE;
               end else begin
                  for (j = pos; j + 1 < length; j++) cells[j] = cells[j+1];
                  length--;
               end
            end
            CMD_SEARCH: begin
               r.status = ST_NOTFOUND;
               for (j = 0; j < length; j++) begin
                  if (cells[j] == value) begin
                     r.status = ST_OK;
                     r.found_index = 6'(j);
                     break;
                  end
               end
            end
            CMD_VISIT: begin
               if (pos >= length) r.status = ST_RANGE;
               else r.read_value = cells[pos];
            end
            CMD_CLEAR: begin
               length = 0;
            end
            default: begin
            end
         endcase
         r.length = 7'(length);
         op_count[cmd]++;
         if (r.status == ST_FULL) n_full++;
         if (r.status == ST_RANGE) n_range++;
         if (cmd == CMD_SEARCH && r.status == ST_OK) n_hit++;
         if (r.status == ST_NOTFOUND) n_miss++;
         if (length > peak_length) peak_length = length;
         pending_rsp.push_back(r);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         if (mismatches < MAX_PRINTED)
            $display("ERROR: response %0d %s: got 0x%0h expected 0x%0h",
                     rsp_seen, field, got, want);
         mismatches++;
      endtask

      task check_response(logic [RSP_W-1:0] d);
         list_rsp_t got;
         list_rsp_t want;
         got = {d[1:0], d[7:2], d[39:8], d[46:40]};
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report("arrived with nothing outstanding", got.read_value, 32'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status != want.status) report("status", got.status, want.status);
            if (got.found_index != want.found_index)
               report("found_index", got.found_index, want.found_index);
            if (got.read_value != want.read_value)
               report("read_value", got.read_value, want.read_value);
            if (got.length != want.length) report("length", got.length, want.length);
         end
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // position [6:0], value [38:7], pad
   logic [CMD_W-1:0] req_tuser = CMD_CLEAR;   // cmd
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;   // status, found_index, read_value, length, pad

   list_shadow sb;
   bit          req_gaps = 1'b1;
   bit          rsp_stalls = 1'b1;
   int unsigned n_sent = 0;

   ordered_list_insert_remove_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: ready most of the time, with stall bursts
   initial begin
      @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [6:0] pos, logic [31:0] value);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.apply_command(cmd, pos, value);
      n_sent++;
   endtask

   // hold the sender until every outstanding response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(bit for_search);
      int r;
      r = $urandom_range(0, 99);
      if (sb.length > 0 && r < (for_search ? 50 : 15))
         return sb.cells[$urandom_range(0, sb.length - 1)];
      r = $urandom_range(0, 99);
      if (r < 35) return 32'($signed($urandom_range(0, 7)) - 4);
      if (r < 45) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [6:0] pick_pos(bit for_insert);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 7'($urandom_range(0, 127));
      if (r == 1) return 7'(for_insert ? sb.length + 1 : sb.length);
      if (r == 2) return 7'd0;
      if (for_insert) return 7'($urandom_range(0, sb.length));
      if (sb.length == 0) return 7'd0;
      return 7'($urandom_range(0, sb.length - 1));
   endfunction

   task automatic random_item(traffic_mode_e mode);
      int ins_pct;
      int rem_pct;
      int srch_pct;
      int vis_pct;
      int r;
      case (mode)
         MODE_FILL:  begin ins_pct = 80; rem_pct = 5;  srch_pct = 8;  vis_pct = 7;  end
         MODE_DRAIN: begin ins_pct = 15; rem_pct = 65; srch_pct = 9;  vis_pct = 10; end
         MODE_PROBE: begin ins_pct = 10; rem_pct = 10; srch_pct = 39; vis_pct = 40; end
         default:    begin ins_pct = 35; rem_pct = 30; srch_pct = 15; vis_pct = 18; end
      endcase
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
         send_cmd(CMD_RESERVED_FIRST + 3'($urandom_range(0, 2)),
                  7'($urandom_range(0, 127)), $urandom);
      else if (r < ins_pct)
         send_cmd(CMD_INSERT, pick_pos(1'b1), pick_value(1'b0));
      else if (r < ins_pct + rem_pct)
         send_cmd(CMD_REMOVE, pick_pos(1'b0), $urandom);
      else if (r < ins_pct + rem_pct + srch_pct)
         send_cmd(CMD_SEARCH, pick_pos(1'b0), pick_value(1'b1));
      else if (r < ins_pct + rem_pct + srch_pct + vis_pct)
         send_cmd(CMD_VISIT, pick_pos(1'b0), $urandom);
      else
         send_cmd(CMD_CLEAR, pick_pos(1'b0), $urandom);
   endtask

   initial begin
      traffic_mode_e mode;
      int k;
      int full_hits;
      int span;
      bit first_round;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty list: every access is out of range, search misses
      send_cmd(CMD_CLEAR, 7'd0, 32'h0);
      send_cmd(CMD_REMOVE, 7'd0, 32'h0);
      send_cmd(CMD_VISIT, 7'd0, 32'h0);
      send_cmd(CMD_SEARCH, 7'd0, 32'd5);
      send_cmd(CMD_INSERT, 7'd1, 32'd9);
      // build -1, 0, min, max, 0 through front, middle and append inserts
      send_cmd(CMD_INSERT, 7'd0, 32'h8000_0000);
      send_cmd(CMD_INSERT, 7'd1, 32'h7FFF_FFFF);
      send_cmd(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
      send_cmd(CMD_INSERT, 7'd1, 32'h0);
      send_cmd(CMD_INSERT, 7'd4, 32'h0);
      send_cmd(CMD_SEARCH, 7'd0, 32'h0);
      send_cmd(CMD_SEARCH, 7'd0, 32'h7FFF_FFFF);
      send_cmd(CMD_VISIT, 7'd0, 32'h0);
      send_cmd(CMD_VISIT, 7'd4, 32'h0);
      send_cmd(CMD_VISIT, 7'd5, 32'h0);
      send_cmd(CMD_REMOVE, 7'd0, 32'h0);
      send_cmd(CMD_REMOVE, 7'd3, 32'h0);
      send_cmd(CMD_REMOVE, 7'd4, 32'h0);
      send_cmd(CMD_INSERT, 7'd127, 32'hFFFF_FFFF);
      send_cmd(CMD_VISIT, 7'd127, 32'h0);
      send_cmd(CMD_RESERVED_FIRST, 7'd127, 32'hA5A5_5A5A);
      send_cmd(CMD_RESERVED_FIRST + 3'd1, 7'd64, 32'h5A5A_A5A5);
      send_cmd(CMD_RESERVED_FIRST + 3'd2, 7'd1, 32'hFFFF_FFFF);
      send_cmd(CMD_SEARCH, 7'd0, 32'd12345);
      send_cmd(CMD_CLEAR, 7'd127, 32'hFFFF_FFFF);
      drain();

      first_round = 1'b1;
      while (n_sent < N_RANDOM + 25) begin
         mode = first_round ? MODE_FILL : traffic_mode_e'($urandom_range(0, 3));
         first_round = 1'b0;
         if (mode == MODE_FILL) begin
            // run until four items leave the list full, or 200 items at most
            full_hits = 0;
            for (k = 0; k < 200 && full_hits < 4; k++) begin
               random_item(MODE_FILL);
               if (sb.length == DEF_CAPACITY) full_hits++;
            end
         end else begin
            span = $urandom_range(20, 80);
            for (k = 0; k < span; k++) random_item(mode);
         end
         if (n_sent >= QUIET_FROM) begin
            req_gaps   = 1'b0;
            rsp_stalls = 1'b0;
         end
         if ($urandom_range(0, 3) == 0) drain();
      end

      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items: insert %0d, remove %0d, search %0d, visit %0d, clear %0d.",
               n_sent, sb.op_count[CMD_INSERT], sb.op_count[CMD_REMOVE],
               sb.op_count[CMD_SEARCH], sb.op_count[CMD_VISIT], sb.op_count[CMD_CLEAR]);
      $display("Full rejects %0d, range errors %0d, search hits %0d / misses %0d, peak length %0d.",
               sb.n_full, sb.n_range, sb.n_hit, sb.n_miss, sb.peak_length);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timeout: responses stopped arriving");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
